[rtl/shs_pkg.sv]
// ---------------------------------------------------------------------------
// shs_pkg
// Shared types and constants for the stepper home search sequencer.
// ---------------------------------------------------------------------------
package shs_pkg;

    // position / counter width
    localparam int POS_WIDTH = 16;
    localparam int BL_WIDTH  = 8;

    // stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_BITS    = 7 + 3 * POS_WIDTH;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // configuration register indexes
    localparam logic [1:0] CFG_BACKLASH = 2'd0;
    localparam logic [1:0] CFG_LIMIT    = 2'd1;
    localparam logic [1:0] CFG_DELTA    = 2'd2;
    localparam logic [1:0] CFG_BARN     = 2'd3;

    // sequencer phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_BL_IN   = 3'd1;
    localparam logic [2:0] PH_BL_OUT  = 3'd2;
    localparam logic [2:0] PH_SEARCH  = 3'd3;
    localparam logic [2:0] PH_INTO    = 3'd4;
    localparam logic [2:0] PH_BACKOUT = 3'd5;

    // error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_HOME  = 2'd1;
    localparam logic [1:0] ERR_LIMIT = 2'd2;
    localparam logic [1:0] ERR_SHORT = 2'd3;

    typedef struct packed {
        logic [BL_WIDTH-1:0]  backlash_steps;
        logic [POS_WIDTH-1:0] search_limit;
        logic [POS_WIDTH-1:0] slit_delta;
        logic [POS_WIDTH-1:0] barn_offset;
    } t_cfg;

    typedef struct packed {
        logic                 motor_enable;
        logic                 step_issued;
        logic                 direction;
        logic                 busy_res;
        logic                 done_res;
        logic [1:0]           error_code;
        logic [POS_WIDTH-1:0] key_position;
        logic [POS_WIDTH-1:0] high_position;
        logic [POS_WIDTH-1:0] barn_position;
    } t_result;

endpackage

[rtl/shs_cfg.sv]
// ---------------------------------------------------------------------------
// shs_cfg
// Configuration register file, write only.
// ---------------------------------------------------------------------------
module shs_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [shs_pkg::POS_WIDTH-1:0] i_cfg_wdata,
    output shs_pkg::t_cfg                o_cfg
);
    import shs_pkg::*;

    t_cfg r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.backlash_steps <= BL_WIDTH'(8);
            r_cfg.search_limit   <= POS_WIDTH'(4096);
            r_cfg.slit_delta     <= '0;
            r_cfg.barn_offset    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BACKLASH: r_cfg.backlash_steps <= i_cfg_wdata[BL_WIDTH-1:0];
                CFG_LIMIT:    r_cfg.search_limit   <= i_cfg_wdata;
                CFG_DELTA:    r_cfg.slit_delta     <= i_cfg_wdata;
                CFG_BARN:     r_cfg.barn_offset    <= i_cfg_wdata;
                default:      r_cfg.barn_offset    <= r_cfg.barn_offset;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/shs_core.sv]
// ---------------------------------------------------------------------------
// shs_core
// Homing phase machine: one tick or start beat per enabled cycle.
// ---------------------------------------------------------------------------
module shs_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic            i_start,
    input  logic            i_home,
    input  logic            i_limit,
    input  shs_pkg::t_cfg   i_cfg,
    output shs_pkg::t_result o_result
);
    import shs_pkg::*;

    logic [2:0]           r_phase, n_phase;
    logic [POS_WIDTH-1:0] r_step, n_step;
    logic [BL_WIDTH-1:0]  r_bl, n_bl;
    logic [POS_WIDTH-1:0] r_key, n_key;
    logic [POS_WIDTH-1:0] r_high, n_high;
    logic [POS_WIDTH-1:0] r_barn, n_barn;
    logic [1:0]           r_err, n_err;

    logic                 fin_done;
    logic                 fin_en;
    logic                 stepped;
    logic                 dir;
    logic [POS_WIDTH-1:0] step_inc;
    logic [POS_WIDTH-1:0] step_dec;
    logic [BL_WIDTH-1:0]  bl_inc;
    logic                 bl_zero;
    logic                 lim_zero;
    logic                 busy;

    assign step_inc = r_step + POS_WIDTH'(1);
    assign step_dec = r_step - POS_WIDTH'(1);
    assign bl_inc   = r_bl + BL_WIDTH'(1);
    assign bl_zero  = (i_cfg.backlash_steps == '0);
    assign lim_zero = (i_cfg.search_limit == '0);

    // next state and result flags
    always_comb begin
        n_phase  = r_phase;
        n_step   = r_step;
        n_bl     = r_bl;
        n_key    = r_key;
        n_high   = r_high;
        n_barn   = r_barn;
        n_err    = r_err;
        fin_done = 1'b0;
        fin_en   = 1'b0;
        stepped  = 1'b0;
        dir      = 1'b0;

        if (i_start) begin
            n_err = ERR_OK;
            if (i_home) begin
                n_phase  = PH_IDLE;
                n_err    = ERR_HOME;
                fin_done = 1'b1;
            end else if (i_limit) begin
                n_phase  = PH_IDLE;
                n_err    = ERR_LIMIT;
                fin_done = 1'b1;
            end else begin
                n_bl = '0;
                if (!bl_zero) begin
                    n_phase = PH_BL_IN;
                end else begin
                    // both takeups skipped: search (idle if limit 0)
                    n_step = '0;
                    if (lim_zero) begin
                        n_phase  = PH_IDLE;
                        n_err    = ERR_HOME;
                        fin_done = 1'b1;
                    end else begin
                        n_phase = PH_SEARCH;
                    end
                end
            end
        end else begin
            case (r_phase)
                PH_BL_IN, PH_BL_OUT: begin
                    stepped = 1'b1;
                    dir     = (r_phase == PH_BL_OUT);
                    n_bl    = bl_inc;
                    if (bl_inc >= i_cfg.backlash_steps) begin
                        if (r_phase == PH_BL_IN && !bl_zero) begin
                            n_bl    = '0;
                            n_phase = PH_BL_OUT;
                        end else begin
                            if (r_phase == PH_BL_IN) begin
                                n_bl = '0;
                            end
                            n_step = '0;
                            if (lim_zero) begin
                                n_phase  = PH_IDLE;
                                n_err    = ERR_HOME;
                                fin_done = 1'b1;
                            end else begin
                                n_phase = PH_SEARCH;
                            end
                        end
                    end
                end
                PH_SEARCH: begin
                    stepped = 1'b1;
                    n_step  = step_inc;
                    if (i_home) begin
                        n_bl    = '0;
                        n_phase = bl_zero ? PH_BACKOUT : PH_INTO;
                    end else if (step_inc >= i_cfg.search_limit) begin
                        n_phase  = PH_IDLE;
                        n_err    = ERR_HOME;
                        fin_done = 1'b1;
                    end
                end
                PH_INTO: begin
                    stepped = 1'b1;
                    n_step  = step_inc;
                    n_bl    = bl_inc;
                    if (bl_inc >= i_cfg.backlash_steps) begin
                        n_phase = PH_BACKOUT;
                    end
                end
                PH_BACKOUT: begin
                    stepped = 1'b1;
                    dir     = 1'b1;
                    n_step  = step_dec;
                    if (step_dec == '0) begin
                        n_phase  = PH_IDLE;
                        n_err    = ERR_HOME;
                        fin_done = 1'b1;
                    end else if (!i_home) begin
                        n_phase  = PH_IDLE;
                        fin_done = 1'b1;
                        if (step_dec < i_cfg.slit_delta) begin
                            n_err = ERR_SHORT;
                        end else begin
                            n_err  = ERR_OK;
                            fin_en = 1'b1;
                            n_key  = step_dec - POS_WIDTH'(1);
                            n_high = step_dec - POS_WIDTH'(1) - i_cfg.slit_delta;
                            n_barn = step_dec - POS_WIDTH'(1) + i_cfg.slit_delta
                                     + i_cfg.barn_offset;
                        end
                    end
                end
                default: begin
                    // idle or unused code
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    assign busy = (n_phase != PH_IDLE);

    // result for this beat
    always_comb begin
        o_result.motor_enable  = busy | fin_en;
        o_result.step_issued   = stepped;
        o_result.direction     = stepped & dir;
        o_result.busy_res      = busy;
        o_result.done_res      = fin_done;
        o_result.error_code    = n_err;
        o_result.key_position  = n_key;
        o_result.high_position = n_high;
        o_result.barn_position = n_barn;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_step  <= '0;
            r_bl    <= '0;
            r_key   <= '0;
            r_high  <= '0;
            r_barn  <= '0;
            r_err   <= ERR_OK;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_bl    <= n_bl;
            r_key   <= n_key;
            r_high  <= n_high;
            r_barn  <= n_barn;
            r_err   <= n_err;
        end
    end

endmodule

[rtl/stepper_home_search_sequencer.sv]
// ---------------------------------------------------------------------------
// stepper_home_search_sequencer
// Slit stepper homing sequencer with backlash takeup, stream in / stream out.
// ---------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  s_axis    in    tvalid / tready    tdata: home_seen, limit_seen; tuser: req_type
//  m_axis    out   tvalid / tready    tdata: result fields (see port)
//  cfg       in    i_cfg_we           i_cfg_idx, i_cfg_wdata
//
//  One beat per cycle sustained while the output is not stalled. A beat is
//  held in the input register, then the phase logic and result register
//  update together. Synchronous active-low reset returns to idle with the
//  valid flags, core state and config at their defaults. A stall on the output
//  holds the result register; the input register still takes a beat while it is empty.
// ---------------------------------------------------------------------------
module stepper_home_search_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [shs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // home_seen, limit_seen, pad
    input  logic                             s_axis_tuser,  // req_type
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // motor_enable, step_issued, direction, busy_res, done_res, error_code[2],
    // key_position, high_position, barn_position, pad
    output logic [shs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_idx,
    input  logic [shs_pkg::POS_WIDTH-1:0]    i_cfg_wdata
);
    import shs_pkg::*;

    logic               r_in_valid;
    logic               r_in_req;
    logic               r_in_home;
    logic               r_in_limit;
    logic               r_out_valid;
    t_result            r_out;
    logic               adv;
    logic               fire;
    t_cfg               cfg;
    t_result            result;
    logic [OUT_BITS-1:0] out_packed;

    assign adv           = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && adv;
    assign s_axis_tready = !r_in_valid || adv;

    shs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    shs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_start  (r_in_req),
        .i_home   (r_in_home),
        .i_limit  (r_in_limit),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_req   <= s_axis_tuser;
            r_in_home  <= s_axis_tdata[0];
            r_in_limit <= s_axis_tdata[1];
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    // pack result fields, motor_enable lowest and barn_position highest
    assign out_packed = {r_out.barn_position, r_out.high_position, r_out.key_position,
                         r_out.error_code, r_out.done_res, r_out.busy_res,
                         r_out.direction, r_out.step_issued, r_out.motor_enable};

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(out_packed);

endmodule
